FILE: hdl/epnrm_pkg.sv
// Package for the eta/phi nearest match block: payload structs, CSR indexes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package epnrm_pkg;

   typedef struct packed {
      logic [2:0]         cand_type;
      logic               is_endcap;
      logic [3:0]         pt_code;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic               last_candidate;
   } req_type;

   typedef struct packed {
      logic [4:0]  matched_pt;
      logic [15:0] min_dr;
      logic        matched;
   } rsp_type;

   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_REF_ETA      = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_REF_PHI      = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MATCH_WINDOW = 2'd2;

   localparam logic [2:0]  CAND_TYPE_ROI   = 3'd2;
   localparam logic [15:0] WINDOW_RESET    = 16'd164;
   localparam logic [15:0] LN2_Q16         = 16'd45426;
   localparam int          PI_Q13          = 25736;
   localparam int          TWO_PI_Q13      = 51472;
   localparam int          HALF_PI_Q16     = 102944;

   // CORDIC datapath widths
   localparam int CordicSteps = 17;
   localparam int CordicXyW   = 35;
   localparam int CordicAngW  = 20;

   // square-root unit: 48-bit radicand, 24-bit root, 2 bits per step
   localparam int SqrtRadW  = 48;
   localparam int SqrtRootW = 24;
   localparam int SqrtSteps = 24;

   // log2 unit: 25-bit operand, Q16 result with 5 integer bits
   localparam int LogOpW  = 25;
   localparam int LogOutW = 21;

   typedef struct packed {
      logic                         valid;
      logic signed [CordicXyW-1:0]  cx;
      logic signed [CordicXyW-1:0]  cy;
      logic signed [CordicAngW-1:0] ang;
   } cordic_type;

   // atan(2^-i) in Q16 radians
   function automatic logic [15:0] cordic_atan(input logic [4:0] step);
      logic [15:0] val;
      case (step)
         5'd0:    val = 16'd51472;
         5'd1:    val = 16'd30386;
         5'd2:    val = 16'd16055;
         5'd3:    val = 16'd8150;
         5'd4:    val = 16'd4091;
         5'd5:    val = 16'd2047;
         5'd6:    val = 16'd1024;
         5'd7:    val = 16'd512;
         5'd8:    val = 16'd256;
         5'd9:    val = 16'd128;
         5'd10:   val = 16'd64;
         5'd11:   val = 16'd32;
         5'd12:   val = 16'd16;
         5'd13:   val = 16'd8;
         5'd14:   val = 16'd4;
         5'd15:   val = 16'd2;
         5'd16:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/epnrm_cordic_cell.sv
// One CORDIC vectoring cell of the phi chain: one micro-rotation per cell.
// Depends on epnrm_pkg (cordic_type, cordic_atan).
`timescale 1ns / 1ps
`default_nettype none
module epnrm_cordic_cell
   import epnrm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [4:0] step,
   input  cordic_type      cell_in,
   output cordic_type      cell_out
);

   cordic_type cell_ff;
   logic signed [CordicXyW-1:0] dx, dy;
   logic signed [CordicAngW-1:0] atan_val;

   always_comb begin
      dx       = $signed(cell_in.cy) >>> step;
      dy       = $signed(cell_in.cx) >>> step;
      atan_val = $signed({{(CordicAngW-16){1'b0}}, cordic_atan(step)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      // rotate toward the x axis
      if (!cell_in.cy[CordicXyW-1]) begin
         cell_ff.cx  <= cell_in.cx + dx;
         cell_ff.cy  <= cell_in.cy - dy;
         cell_ff.ang <= cell_in.ang + atan_val;
      end else begin
         cell_ff.cx  <= cell_in.cx - dx;
         cell_ff.cy  <= cell_in.cy + dy;
         cell_ff.ang <= cell_in.ang - atan_val;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

FILE: hdl/epnrm_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on epnrm_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none
module epnrm_sqrt
   import epnrm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SqrtRadW-1:0]  radicand,
   output logic                      done,
   output logic [SqrtRootW-1:0]      root
);

   localparam int CntW = $clog2(SqrtSteps);
   localparam int RemW = SqrtRootW + 2;

   logic                 busy_ff, done_ff;
   logic [CntW-1:0]      cnt_ff;
   logic [SqrtRadW-1:0]  rad_ff;
   logic [RemW-1:0]      rem_ff;
   logic [SqrtRootW-1:0] root_ff;
   logic [RemW:0]        rem_sh, trial;

   always_comb begin
      rem_sh = {rem_ff[RemW-2:0], rad_ff[SqrtRadW-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CntW'(SqrtSteps - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff <= rad_ff << 2;
         cnt_ff <= cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_ff  <= RemW'(rem_sh - trial);
            root_ff <= {root_ff[SqrtRootW-2:0], 1'b1};
         end else begin
            rem_ff  <= RemW'(rem_sh);
            root_ff <= {root_ff[SqrtRootW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

FILE: hdl/epnrm_log2.sv
// Iterative log2 in Q16: leading-one normalize, then one squaring per fraction bit.
// Depends on epnrm_pkg (widths).
`timescale 1ns / 1ps
`default_nettype none
module epnrm_log2
   import epnrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [LogOpW-1:0]  operand,
   output logic                    done,
   output logic [LogOutW-1:0]      result
);

   logic              busy_ff, done_ff;
   logic [3:0]        cnt_ff;
   logic [30:0]       m_ff;
   logic [LogOutW-1:0] out_ff;
   logic [4:0]        msb;
   logic [30:0]       m_norm;
   logic [61:0]       sq;
   logic [31:0]       sq_hi;

   always_comb begin
      msb = '0;
      for (int i = 0; i < LogOpW; i++) begin
         if (operand[i]) msb = 5'(i);
      end
      m_norm = {{(31-LogOpW){1'b0}}, operand} << (5'd30 - msb);
      sq     = m_ff * m_ff;
      sq_hi  = sq[61:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 4'd15) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         m_ff   <= m_norm;
         out_ff <= {msb, 16'd0};
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (sq_hi[31]) begin
            m_ff           <= sq_hi[31:1];
            out_ff[~cnt_ff] <= 1'b1;
         end else begin
            m_ff <= sq_hi[30:0];
         end
      end
   end

   assign done   = done_ff;
   assign result = out_ff;

endmodule
`default_nettype wire

FILE: hdl/eta_phi_nearest_roi_match.sv
// Top level of the eta/phi nearest candidate match: sequencer, CORDIC cell chain,
// shared root and log2 units. Depends on epnrm_pkg, epnrm_cordic_cell, epnrm_sqrt, epnrm_log2.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  ports                          direction  moves
//  -------  -----------------------------  ---------  ------------------------------
//  req      req_valid req_stall req_data   in         one candidate per transaction
//  rsp      rsp_valid rsp_stall rsp_data   out        one match result per scan
//  csr      csr_we csr_index csr_wdata     in         ref_eta, ref_phi, match_window
//
//  A skipped candidate is dropped in S_IDLE. A kept one runs three 24-step root passes
//  (r, rho, delta-R) and two 16-step log2 passes, one after another (only delta-R if x=y=0).
//  phi comes from a 17-cell CORDIC chain launched early, hidden under the root passes.
//  Reset (synchronous) clears the sequencer, the running best and the CSRs to defaults.
//  req_stall is high outside S_IDLE; a finished result waits in the output
//  register and only blocks the sequencer when the next result is ready too.
//
module eta_phi_nearest_roi_match
   import epnrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [15:0]        csr_wdata
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_SQ        = 13'b0000000000010,
      S_SUMS      = 13'b0000000000100,
      S_SQRT_R    = 13'b0000000001000,
      S_SQRT_RHO  = 13'b0000000010000,
      S_LOG_A     = 13'b0000000100000,
      S_LOG_B     = 13'b0000001000000,
      S_ETA       = 13'b0000010000000,
      S_DELTA     = 13'b0000100000000,
      S_SQR2      = 13'b0001000000000,
      S_SUM_DR    = 13'b0010000000000,
      S_SQRT_DR   = 13'b0100000000000,
      S_EMIT      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [15:0] ref_eta_ff, ref_phi_ff;
   logic [15:0]        match_window_ff;

   // candidate and working registers
   req_type            item_ff;
   logic [30:0]        xx_ff, yy_ff, zz_ff;
   logic [31:0]        rho2_ff;
   logic [SqrtRootW-1:0] rq_ff;
   logic [LogOutW-1:0] la_ff;
   logic [36:0]        prod_ff;
   logic signed [15:0] eta_ff, phi_ff;
   logic [16:0]        a_ff;
   logic [14:0]        b_ff;
   logic [33:0]        aa_ff;
   logic [29:0]        bb_ff;
   logic [15:0]        best_dr_ff;
   logic [4:0]         best_pt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // handshake
   logic req_take, rsp_free, kept;
   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign kept      = (req_data.cand_type == CAND_TYPE_ROI) && req_data.is_endcap
                      && (req_data.pt_code != 4'd0);

   // ---------------- CORDIC chain for phi ----------------
   cordic_type chain [0:CordicSteps];
   logic       axis;
   logic signed [CordicXyW-1:0] x_sc, y_sc;

   assign axis = (item_ff.pos_x == 16'sd0) && (item_ff.pos_y == 16'sd0);

   always_comb begin
      x_sc = $signed({{(CordicXyW-32){item_ff.pos_x[15]}}, item_ff.pos_x, 16'd0});
      y_sc = $signed({{(CordicXyW-32){item_ff.pos_y[15]}}, item_ff.pos_y, 16'd0});
      chain[0].valid = (state_ff == S_SQ) && !axis;
      // quarter-turn pre-rotation for the left half plane
      if (x_sc < 0) begin
         if (y_sc >= 0) begin
            chain[0].cx  = y_sc;
            chain[0].cy  = -x_sc;
            chain[0].ang = CordicAngW'(HALF_PI_Q16);
         end else begin
            chain[0].cx  = -y_sc;
            chain[0].cy  = x_sc;
            chain[0].ang = -CordicAngW'(HALF_PI_Q16);
         end
      end else begin
         chain[0].cx  = x_sc;
         chain[0].cy  = y_sc;
         chain[0].ang = '0;
      end
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
      epnrm_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (5'(i)),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // Q16 angle rounded to Q13 and clamped to +/- pi
   logic signed [CordicAngW-1:0] ang_rnd;
   logic signed [15:0]           phi_new;
   always_comb begin
      ang_rnd = (chain[CordicSteps].ang + CordicAngW'(4)) >>> 3;
      if (ang_rnd > CordicAngW'(PI_Q13))       phi_new = 16'(PI_Q13);
      else if (ang_rnd < -CordicAngW'(PI_Q13)) phi_new = -16'(PI_Q13);
      else                                     phi_new = ang_rnd[15:0];
   end

   // ---------------- shared root and log2 units ----------------
   logic                 sqrt_start, sqrt_done;
   logic [SqrtRadW-1:0]  sqrt_op;
   logic [SqrtRootW-1:0] sqrt_root;
   logic                 log_start, log_done;
   logic [LogOpW-1:0]    log_op;
   logic [LogOutW-1:0]   log_res;

   epnrm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_op),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   epnrm_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .operand (log_op),
      .done    (log_done),
      .result  (log_res)
   );

   // ---------------- datapath combinational ----------------
   logic signed [31:0] sx, sy, sz;
   logic [31:0]        r2_sum;
   logic [15:0]        az;
   logic [LogOutW-1:0] diff;
   logic [17:0]        mag;
   logic signed [15:0] eta_new;
   logic signed [17:0] deta, dphi_raw, dphi;
   logic [34:0]        dr2;
   logic [19:0]        s_rnd;
   logic [15:0]        s_sat;
   logic [4:0]         pt_gev;
   logic               hit;

   always_comb begin
      sx     = item_ff.pos_x * item_ff.pos_x;
      sy     = item_ff.pos_y * item_ff.pos_y;
      sz     = item_ff.pos_z * item_ff.pos_z;
      r2_sum = {1'b0, xx_ff} + {1'b0, yy_ff};
      az     = item_ff.pos_z[15] ? 16'(-item_ff.pos_z) : item_ff.pos_z;

      diff = (la_ff > log_res) ? LogOutW'(la_ff - log_res) : '0;
      // |eta| rounded half up to Q12, sign from z
      mag = 18'((38'(prod_ff) + 38'(1 << 19)) >> 20);
      if (item_ff.pos_z > 0)
         eta_new = (mag > 18'd32767) ? 16'sd32767 : $signed(mag[15:0]);
      else if (item_ff.pos_z < 0)
         eta_new = (mag > 18'd32768) ? -16'sd32768 : $signed(16'(-mag));
      else
         eta_new = 16'sd0;

      deta     = 18'(ref_eta_ff) - 18'(eta_ff);
      dphi_raw = 18'(ref_phi_ff) - 18'(phi_ff);
      // one wrap step covers the whole input range
      if (dphi_raw >= 18'(PI_Q13))       dphi = dphi_raw - 18'(TWO_PI_Q13);
      else if (dphi_raw < -18'(PI_Q13))  dphi = dphi_raw + 18'(TWO_PI_Q13);
      else                               dphi = dphi_raw;

      dr2   = {1'b0, aa_ff} + {5'd0, bb_ff};
      s_rnd = ({1'b0, sqrt_root[18:0]} + 20'd1) >> 1;
      s_sat = (s_rnd > 20'd65535) ? 16'hFFFF : s_rnd[15:0];

      if (item_ff.pt_code <= 4'd13)      pt_gev = {1'b0, item_ff.pt_code} + 5'd2;
      else if (item_ff.pt_code == 4'd14) pt_gev = 5'd18;
      else                               pt_gev = 5'd20;

      hit = (best_pt_ff != 5'd0) && (best_dr_ff <= match_window_ff);
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      sqrt_start = 1'b0;
      sqrt_op    = '0;
      log_start  = 1'b0;
      log_op     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (kept)                         state_in = S_SQ;
               else if (req_data.last_candidate) state_in = S_EMIT;
            end
         end
         S_SQ: state_in = S_SUMS;
         S_SUMS: begin
            sqrt_start = !axis;
            sqrt_op    = {r2_sum, 16'd0};
            state_in   = axis ? S_DELTA : S_SQRT_R;
         end
         S_SQRT_R: begin
            if (sqrt_done) begin
               sqrt_start = 1'b1;
               sqrt_op    = {rho2_ff, 16'd0};
               state_in   = S_SQRT_RHO;
            end
         end
         S_SQRT_RHO: begin
            if (sqrt_done) begin
               log_start = 1'b1;
               log_op    = {1'b0, az, 8'd0} + {1'b0, sqrt_root};
               state_in  = S_LOG_A;
            end
         end
         S_LOG_A: begin
            if (log_done) begin
               log_start = 1'b1;
               log_op    = {1'b0, rq_ff};
               state_in  = S_LOG_B;
            end
         end
         S_LOG_B: if (log_done) state_in = S_ETA;
         S_ETA:    state_in = S_DELTA;
         S_DELTA:  state_in = S_SQR2;
         S_SQR2:   state_in = S_SUM_DR;
         S_SUM_DR: begin
            sqrt_start = 1'b1;
            sqrt_op    = {13'd0, dr2};
            state_in   = S_SQRT_DR;
         end
         S_SQRT_DR: begin
            if (sqrt_done) state_in = item_ff.last_candidate ? S_EMIT : S_IDLE;
         end
         S_EMIT: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         ref_eta_ff      <= '0;
         ref_phi_ff      <= '0;
         match_window_ff <= WINDOW_RESET;
         best_dr_ff      <= 16'hFFFF;
         best_pt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_REF_ETA:      ref_eta_ff      <= csr_wdata;
               CSR_REF_PHI:      ref_phi_ff      <= csr_wdata;
               CSR_MATCH_WINDOW: match_window_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_SQRT_DR && sqrt_done && s_sat < best_dr_ff) begin
            best_dr_ff <= s_sat;
            best_pt_ff <= pt_gev;
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == S_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            best_dr_ff   <= 16'hFFFF;
            best_pt_ff   <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) item_ff <= req_data;
      if (state_ff == S_SQ) begin
         xx_ff <= sx[30:0];
         yy_ff <= sy[30:0];
         zz_ff <= sz[30:0];
      end
      if (state_ff == S_SUMS) begin
         rho2_ff <= r2_sum + {1'b0, zz_ff};
         if (axis) begin
            phi_ff <= '0;
            if (item_ff.pos_z > 0)      eta_ff <= 16'sd32767;
            else if (item_ff.pos_z < 0) eta_ff <= -16'sd32768;
            else                        eta_ff <= 16'sd0;
         end
      end
      if (chain[CordicSteps].valid) phi_ff <= phi_new;
      if (state_ff == S_SQRT_R && sqrt_done) rq_ff <= sqrt_root;
      if (state_ff == S_LOG_A && log_done) la_ff <= log_res;
      if (state_ff == S_LOG_B && log_done) prod_ff <= diff * LN2_Q16;
      if (state_ff == S_ETA) eta_ff <= eta_new;
      if (state_ff == S_DELTA) begin
         a_ff <= 17'(deta[17] ? -deta : deta) << 1;
         b_ff <= 15'(dphi[17] ? -dphi : dphi);
      end
      if (state_ff == S_SQR2) begin
         aa_ff <= a_ff * a_ff;
         bb_ff <= b_ff * b_ff;
      end
      if (state_ff == S_EMIT && rsp_free) begin
         rsp_ff.matched_pt <= hit ? best_pt_ff : 5'd0;
         rsp_ff.min_dr     <= best_dr_ff;
         rsp_ff.matched    <= hit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
